/* hw/rtl/padcfn_pkg.sv */
// Shared types and constants of the pedal ADC filter and normalizer.
// Used by the top level and by its port checker; depends on nothing.
package padcfn_pkg;

  localparam int unsigned SampleW  = 12;
  localparam int unsigned FiltW    = 20;
  localparam int unsigned PosW     = 13;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 12;
  localparam int unsigned AlphaW   = 14;
  localparam int unsigned ProdW    = FiltW + AlphaW;
  localparam int unsigned NumW     = FiltW + 4;
  localparam int unsigned TrialW   = NumW + 2;
  localparam int unsigned CntW     = 4;

  // Filter gain of about 0.15 in Q0.16.
  localparam logic [AlphaW-1:0]   Alpha    = 14'd9830;
  localparam logic [PosW-1:0]     QOne     = 13'd4096;
  localparam logic [FiltW-1:0]    FiltMax  = 20'hFFF00;
  localparam logic [ProdW-1:0]    RoundUp  = 34'd65535;
  // Quotient bits 12..0; a set trial at bit 13 means the result clamps.
  localparam logic [CntW-1:0]     DivTop   = 4'd13;

  localparam logic [SampleW-1:0]  CalLowRst  = 12'd300;
  localparam logic [SampleW-1:0]  CalHighRst = 12'd3800;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_BRAKE_LOW  = 3'd0,
    CFG_BRAKE_HIGH = 3'd1,
    CFG_BRAKE_INV  = 3'd2,
    CFG_ACCEL_LOW  = 3'd3,
    CFG_ACCEL_HIGH = 3'd4,
    CFG_ACCEL_INV  = 3'd5
  } cfg_idx_t;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_DIFF = 7'b0000010,
    ST_MUL  = 7'b0000100,
    ST_UPD  = 7'b0001000,
    ST_NORM = 7'b0010000,
    ST_DIV  = 7'b0100000,
    ST_DONE = 7'b1000000
  } state_t;

endpackage

/* hw/rtl/pedal_adc_filter_normalizer_top.sv */
// Top level of the two-channel pedal ADC filter and normalizer.
// Depends on padcfn_pkg for widths, constants and the sequencer states.
//
// The input channel (in_valid/in_ready) carries one ADC sample and its pedal
// (0 brake, 1 accelerator). Each transfer updates that pedal's Q12.8
// exponential average and yields one result on the output channel: the pedal,
// the raw sample, the filtered value and the Q12 position (4096 is fully pressed).
// The configuration channel is always ready and writes the calibration ends and
// invert bits by register index; it should be used only while the block is
// idle. Unknown indexes are dropped.
// A sample runs through difference, multiply, update, normalize setup and 14
// steps of one shared restoring subtractor. When the filtered value is at or
// below the low end the divide is skipped; a saturating quotient ends it after
// its first step. in_ready is high only while the sequencer idles. A stalled
// result waits in the output register; the next sample is still taken and then
// holds in its last step. Reset clears both filter values and restores low 300,
// high 3800, no invert.
module pedal_adc_filter_normalizer_top (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_channel,
  input  logic [padcfn_pkg::SampleW-1:0]     in_sample,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_channel,
  output logic [padcfn_pkg::SampleW-1:0]     out_raw_echo,
  output logic [padcfn_pkg::FiltW-1:0]       out_smoothed,
  output logic [padcfn_pkg::PosW-1:0]        out_position,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [padcfn_pkg::CfgIdxW-1:0]     cfg_index,
  input  logic [padcfn_pkg::CfgDataW-1:0]    cfg_data
);

  padcfn_pkg::state_t state_r, state_nxt;

  logic [padcfn_pkg::SampleW-1:0] cal_lo_r [2];
  logic [padcfn_pkg::SampleW-1:0] cal_hi_r [2];
  logic                           inv_r    [2];
  logic [padcfn_pkg::FiltW-1:0]   filt_r   [2];
  logic [padcfn_pkg::FiltW-1:0]   filt_nxt [2];

  logic                           ch_r, ch_nxt;
  logic [padcfn_pkg::SampleW-1:0] smp_r, smp_nxt;
  logic [padcfn_pkg::FiltW-1:0]   fv_r, fv_nxt;
  logic [padcfn_pkg::FiltW-1:0]   mag_r, mag_nxt;
  logic                           neg_r, neg_nxt;
  logic [padcfn_pkg::ProdW-1:0]   prod_r, prod_nxt;
  logic [padcfn_pkg::NumW-1:0]    rem_r, rem_nxt;
  logic [padcfn_pkg::SampleW-1:0] span_r, span_nxt;
  logic [padcfn_pkg::PosW-1:0]    quo_r, quo_nxt;
  logic [padcfn_pkg::CntW-1:0]    cnt_r, cnt_nxt;

  logic                           out_valid_r, out_valid_nxt;
  logic                           out_ch_r, out_ch_nxt;
  logic [padcfn_pkg::SampleW-1:0] out_raw_r, out_raw_nxt;
  logic [padcfn_pkg::FiltW-1:0]   out_sm_r, out_sm_nxt;
  logic [padcfn_pkg::PosW-1:0]    out_pos_r, out_pos_nxt;

  logic [padcfn_pkg::FiltW-1:0]   target;
  logic [17:0]                    step;
  logic [padcfn_pkg::ProdW-1:0]   prod_rnd;
  logic [padcfn_pkg::SampleW-1:0] lo, hi, diff;
  logic [padcfn_pkg::FiltW-1:0]   base;
  logic [padcfn_pkg::TrialW-1:0]  trial;
  logic [padcfn_pkg::PosW-1:0]    clamped;

  assign in_ready  = (state_r == padcfn_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;

  assign out_valid    = out_valid_r;
  assign out_channel  = out_ch_r;
  assign out_raw_echo = out_raw_r;
  assign out_smoothed = out_sm_r;
  assign out_position = out_pos_r;

  // Datapath terms, each used in one sequencer step.
  assign target   = {smp_r, 8'd0};
  assign prod_rnd = prod_r + padcfn_pkg::RoundUp;
  assign step     = neg_r ? prod_rnd[padcfn_pkg::ProdW-1:16] : prod_r[padcfn_pkg::ProdW-1:16];
  assign lo       = (cal_lo_r[ch_r] < cal_hi_r[ch_r]) ? cal_lo_r[ch_r] : cal_hi_r[ch_r];
  assign hi       = (cal_lo_r[ch_r] < cal_hi_r[ch_r]) ? cal_hi_r[ch_r] : cal_lo_r[ch_r];
  assign diff     = hi - lo;
  assign base     = {lo, 8'd0};
  // The shared subtractor: remainder minus the span aligned to the current bit.
  assign trial    = {2'b00, rem_r}
                  - (padcfn_pkg::TrialW'(span_r) << cnt_r);
  assign clamped  = (quo_r > padcfn_pkg::QOne) ? padcfn_pkg::QOne : quo_r;

  always_comb begin
    state_nxt     = state_r;
    ch_nxt        = ch_r;
    smp_nxt       = smp_r;
    fv_nxt        = fv_r;
    mag_nxt       = mag_r;
    neg_nxt       = neg_r;
    prod_nxt      = prod_r;
    rem_nxt       = rem_r;
    span_nxt      = span_r;
    quo_nxt       = quo_r;
    cnt_nxt       = cnt_r;
    filt_nxt      = filt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_ch_nxt    = out_ch_r;
    out_raw_nxt   = out_raw_r;
    out_sm_nxt    = out_sm_r;
    out_pos_nxt   = out_pos_r;

    unique case (state_r)
      padcfn_pkg::ST_IDLE: begin
        if (in_valid) begin
          ch_nxt    = in_channel;
          smp_nxt   = in_sample;
          fv_nxt    = filt_r[in_channel];
          state_nxt = padcfn_pkg::ST_DIFF;
        end
      end
      padcfn_pkg::ST_DIFF: begin
        // Work on the magnitude so that the downward step rounds toward minus infinity.
        if (target >= fv_r) begin
          mag_nxt = target - fv_r;
          neg_nxt = 1'b0;
        end else begin
          mag_nxt = fv_r - target;
          neg_nxt = 1'b1;
        end
        state_nxt = padcfn_pkg::ST_MUL;
      end
      padcfn_pkg::ST_MUL: begin
        prod_nxt  = padcfn_pkg::ProdW'(mag_r) * padcfn_pkg::ProdW'(padcfn_pkg::Alpha);
        state_nxt = padcfn_pkg::ST_UPD;
      end
      padcfn_pkg::ST_UPD: begin
        fv_nxt = neg_r ? (fv_r - padcfn_pkg::FiltW'(step))
                       : (fv_r + padcfn_pkg::FiltW'(step));
        filt_nxt[ch_r] = fv_nxt;
        state_nxt      = padcfn_pkg::ST_NORM;
      end
      padcfn_pkg::ST_NORM: begin
        span_nxt = (diff == '0) ? padcfn_pkg::SampleW'(1) : diff;
        quo_nxt  = '0;
        if (fv_r <= base) begin
          state_nxt = padcfn_pkg::ST_DONE;
        end else begin
          rem_nxt   = {fv_r - base, 4'd0};
          cnt_nxt   = padcfn_pkg::DivTop;
          state_nxt = padcfn_pkg::ST_DIV;
        end
      end
      padcfn_pkg::ST_DIV: begin
        if (!trial[padcfn_pkg::TrialW-1]) begin
          if (cnt_r == padcfn_pkg::DivTop) begin
            // Quotient of 8192 or more: the position saturates.
            quo_nxt   = padcfn_pkg::QOne;
            state_nxt = padcfn_pkg::ST_DONE;
          end else begin
            rem_nxt = trial[padcfn_pkg::NumW-1:0];
            quo_nxt[cnt_r] = 1'b1;
          end
        end
        if (cnt_r == '0) begin
          state_nxt = padcfn_pkg::ST_DONE;
        end
        cnt_nxt = cnt_r - 1'b1;
      end
      padcfn_pkg::ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_ch_nxt    = ch_r;
          out_raw_nxt   = smp_r;
          out_sm_nxt    = fv_r;
          out_pos_nxt   = inv_r[ch_r] ? (padcfn_pkg::QOne - clamped) : clamped;
          state_nxt     = padcfn_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = padcfn_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= padcfn_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      filt_r[0]   <= '0;
      filt_r[1]   <= '0;
      cal_lo_r[0] <= padcfn_pkg::CalLowRst;
      cal_lo_r[1] <= padcfn_pkg::CalLowRst;
      cal_hi_r[0] <= padcfn_pkg::CalHighRst;
      cal_hi_r[1] <= padcfn_pkg::CalHighRst;
      inv_r[0]    <= 1'b0;
      inv_r[1]    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      filt_r      <= filt_nxt;
      if (cfg_valid) begin
        unique case (padcfn_pkg::cfg_idx_t'(cfg_index))
          padcfn_pkg::CFG_BRAKE_LOW:  cal_lo_r[0] <= cfg_data;
          padcfn_pkg::CFG_BRAKE_HIGH: cal_hi_r[0] <= cfg_data;
          padcfn_pkg::CFG_BRAKE_INV:  inv_r[0]    <= cfg_data[0];
          padcfn_pkg::CFG_ACCEL_LOW:  cal_lo_r[1] <= cfg_data;
          padcfn_pkg::CFG_ACCEL_HIGH: cal_hi_r[1] <= cfg_data;
          padcfn_pkg::CFG_ACCEL_INV:  inv_r[1]    <= cfg_data[0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    ch_r      <= ch_nxt;
    smp_r     <= smp_nxt;
    fv_r      <= fv_nxt;
    mag_r     <= mag_nxt;
    neg_r     <= neg_nxt;
    prod_r    <= prod_nxt;
    rem_r     <= rem_nxt;
    span_r    <= span_nxt;
    quo_r     <= quo_nxt;
    cnt_r     <= cnt_nxt;
    out_ch_r  <= out_ch_nxt;
    out_raw_r <= out_raw_nxt;
    out_sm_r  <= out_sm_nxt;
    out_pos_r <= out_pos_nxt;
  end

endmodule

/* hw/rtl/padcfn_checker.sv */
// Port-level checker for the pedal ADC filter and normalizer, bound to the top level.
// Depends on padcfn_pkg for field widths and the Q12 full-scale constant.
module padcfn_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic                               out_channel,
  input logic [padcfn_pkg::SampleW-1:0]     out_raw_echo,
  input logic [padcfn_pkg::FiltW-1:0]       out_smoothed,
  input logic [padcfn_pkg::PosW-1:0]        out_position
);

  // A stalled result keeps its whole payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_channel)
      && $stable(out_raw_echo) && $stable(out_smoothed) && $stable(out_position))
    else $error("stalled result changed");

  // The position never exceeds full scale.
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_position <= padcfn_pkg::QOne)
    else $error("position above full scale");

  // The filtered value stays within the range of a shifted 12-bit sample.
  a_smooth_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_smoothed <= padcfn_pkg::FiltMax)
    else $error("filtered value out of range");

  // After an input transfer the block is busy and in_ready drops.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready ##1 !in_ready)
    else $error("input taken while a sample is in progress");

endmodule

bind pedal_adc_filter_normalizer_top padcfn_checker u_padcfn_checker (.*);

/* verif/tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the two-channel pedal ADC filter and normalizer.
// Needs padcfn_pkg and pedal_adc_filter_normalizer_top; it predicts each result itself.
module tb;

  localparam logic PedBrake = 1'b0;
  localparam logic PedAccel = 1'b1;
  // Register indexes beyond the six real ones; the block must drop them.
  localparam logic [padcfn_pkg::CfgIdxW-1:0] CfgSpareA = 3'd6;
  localparam logic [padcfn_pkg::CfgIdxW-1:0] CfgSpareB = 3'd7;
  localparam int RandItemsPerPhase = 315;
  localparam int StallItems = 40;
  localparam int HoldCycles = 400;
  localparam int TailCycles = 40;
  localparam logic [padcfn_pkg::SampleW-1:0] AdcMax = 12'd4095;

  typedef struct packed {
    logic                           channel;
    logic [padcfn_pkg::SampleW-1:0] raw;
    logic [padcfn_pkg::FiltW-1:0]   smoothed;
    logic [padcfn_pkg::PosW-1:0]    position;
  } pedal_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_channel = 1'b0;
  logic [padcfn_pkg::SampleW-1:0] in_sample = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_channel;
  logic [padcfn_pkg::SampleW-1:0] out_raw_echo;
  logic [padcfn_pkg::FiltW-1:0] out_smoothed;
  logic [padcfn_pkg::PosW-1:0] out_position;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [padcfn_pkg::CfgIdxW-1:0] cfg_index = '0;
  logic [padcfn_pkg::CfgDataW-1:0] cfg_data = '0;

  // Predictor copy of the block's state and calibration, indexed by pedal.
  logic [padcfn_pkg::FiltW-1:0] filt_state[2];
  logic [padcfn_pkg::SampleW-1:0] cal_lo[2];
  logic [padcfn_pkg::SampleW-1:0] cal_hi[2];
  logic cal_inv[2];
  logic [padcfn_pkg::SampleW-1:0] last_sample[2];

  pedal_result_t pending_results[$];
  int error_count = 0;
  int sent_count = 0;
  int checked_count = 0;
  int settings_count = 0;
  bit tx_idle = 1'b1;
  bit rx_idle = 1'b1;
  int rx_hold_cycles = 0;

  pedal_adc_filter_normalizer_top uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_channel   (in_channel),
    .in_sample    (in_sample),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_channel  (out_channel),
    .out_raw_echo (out_raw_echo),
    .out_smoothed (out_smoothed),
    .out_position (out_position),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Updates the pedal's filter and returns the result the block should give.
  function automatic pedal_result_t advance_pedal(input logic ch,
                                                  input logic [padcfn_pkg::SampleW-1:0] s);
    logic [padcfn_pkg::FiltW-1:0] f;
    logic [padcfn_pkg::FiltW-1:0] target;
    logic [padcfn_pkg::FiltW-1:0] base;
    logic [padcfn_pkg::ProdW-1:0] prod;
    logic [padcfn_pkg::SampleW-1:0] lo;
    logic [padcfn_pkg::SampleW-1:0] hi;
    logic [padcfn_pkg::SampleW-1:0] span;
    logic [padcfn_pkg::NumW-1:0] quo;
    logic [padcfn_pkg::PosW-1:0] pos;
    pedal_result_t r;
    f = filt_state[ch];
    target = {s, 8'h00};
    // Rising steps round down, falling steps round up, so both floor the signed step.
    if (target >= f) begin
      prod = (target - f) * padcfn_pkg::Alpha;
      f = f + prod[padcfn_pkg::ProdW-1:16];
    end else begin
      prod = (f - target) * padcfn_pkg::Alpha;
      prod = (prod + padcfn_pkg::RoundUp) >> 16;
      f = f - prod[padcfn_pkg::FiltW-1:0];
    end
    filt_state[ch] = f;
    lo = (cal_lo[ch] < cal_hi[ch]) ? cal_lo[ch] : cal_hi[ch];
    hi = (cal_lo[ch] < cal_hi[ch]) ? cal_hi[ch] : cal_lo[ch];
    span = hi - lo;
    if (span == '0) begin
      span = 12'd1;
    end
    base = {lo, 8'h00};
    if (f <= base) begin
      quo = '0;
    end else begin
      quo = {f - base, 4'h0} / span;
    end
    pos = (quo > padcfn_pkg::QOne) ? padcfn_pkg::QOne : quo[padcfn_pkg::PosW-1:0];
    if (cal_inv[ch]) begin
      pos = padcfn_pkg::QOne - pos;
    end
    r.channel = ch;
    r.raw = s;
    r.smoothed = f;
    r.position = pos;
    return r;
  endfunction

  task automatic send_sample(input logic ch, input logic [padcfn_pkg::SampleW-1:0] s);
    int unsigned gap;
    gap = tx_idle ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_channel <= ch;
    in_sample <= s;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(advance_pedal(ch, s));
    last_sample[ch] = s;
    sent_count++;
  endtask

  // Stops offering samples and waits until every result has come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [padcfn_pkg::CfgIdxW-1:0] idx,
                           input logic [padcfn_pkg::CfgDataW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      padcfn_pkg::CFG_BRAKE_LOW:  cal_lo[PedBrake] = data;
      padcfn_pkg::CFG_BRAKE_HIGH: cal_hi[PedBrake] = data;
      padcfn_pkg::CFG_BRAKE_INV:  cal_inv[PedBrake] = data[0];
      padcfn_pkg::CFG_ACCEL_LOW:  cal_lo[PedAccel] = data;
      padcfn_pkg::CFG_ACCEL_HIGH: cal_hi[PedAccel] = data;
      padcfn_pkg::CFG_ACCEL_INV:  cal_inv[PedAccel] = data[0];
      default: ;
    endcase
  endtask

  // Invert words may carry set upper bits, which the block must ignore.
  task automatic program_calibration(input logic [padcfn_pkg::SampleW-1:0] b_lo,
                                     input logic [padcfn_pkg::SampleW-1:0] b_hi,
                                     input logic [padcfn_pkg::CfgDataW-1:0] b_inv,
                                     input logic [padcfn_pkg::SampleW-1:0] a_lo,
                                     input logic [padcfn_pkg::SampleW-1:0] a_hi,
                                     input logic [padcfn_pkg::CfgDataW-1:0] a_inv,
                                     input bit spare);
    wait_drained();
    write_reg(padcfn_pkg::CFG_BRAKE_LOW, b_lo);
    write_reg(padcfn_pkg::CFG_BRAKE_HIGH, b_hi);
    write_reg(padcfn_pkg::CFG_BRAKE_INV, b_inv);
    write_reg(padcfn_pkg::CFG_ACCEL_LOW, a_lo);
    write_reg(padcfn_pkg::CFG_ACCEL_HIGH, a_hi);
    write_reg(padcfn_pkg::CFG_ACCEL_INV, a_inv);
    if (spare) begin
      write_reg(CfgSpareA, padcfn_pkg::CfgDataW'($urandom_range(0, 4095)));
      write_reg(CfgSpareB, padcfn_pkg::CfgDataW'($urandom_range(0, 4095)));
    end
    cfg_valid <= 1'b0;
    settings_count++;
  endtask

  task automatic draw_calibration(output logic [padcfn_pkg::SampleW-1:0] lo,
                                  output logic [padcfn_pkg::SampleW-1:0] hi);
    logic [padcfn_pkg::SampleW-1:0] a;
    logic [padcfn_pkg::SampleW-1:0] b;
    a = padcfn_pkg::SampleW'($urandom_range(0, 4000));
    b = padcfn_pkg::SampleW'($urandom_range(0, 4095));
    case ($urandom_range(0, 5))
      0: begin
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
      end
      1: begin
        lo = (a < b) ? b : a;
        hi = (a < b) ? a : b;
      end
      2: begin
        lo = a;
        hi = a;
      end
      3: begin
        lo = '0;
        hi = AdcMax;
      end
      4: begin
        lo = AdcMax;
        hi = '0;
      end
      default: begin
        lo = a;
        hi = a + padcfn_pkg::SampleW'($urandom_range(1, 60));
      end
    endcase
  endtask

  // Mixes uniform samples with ones near the calibration ends, rail values
  // and repeats, so the filter settles at both ends and across the clamps.
  function automatic logic [padcfn_pkg::SampleW-1:0] draw_sample(input logic ch);
    int v;
    int lo;
    int hi;
    lo = (cal_lo[ch] < cal_hi[ch]) ? cal_lo[ch] : cal_hi[ch];
    hi = (cal_lo[ch] < cal_hi[ch]) ? cal_hi[ch] : cal_lo[ch];
    case ($urandom_range(0, 5))
      0, 1: v = $urandom_range(0, 4095);
      2: v = lo + int'($urandom_range(0, 64)) - 32;
      3: v = hi + int'($urandom_range(0, 64)) - 32;
      4: v = $urandom_range(0, 1) ? 4095 : 0;
      default: v = last_sample[ch];
    endcase
    if (v < 0) begin
      v = 0;
    end else if (v > 4095) begin
      v = 4095;
    end
    return v[padcfn_pkg::SampleW-1:0];
  endfunction

  task automatic send_random_items(input int count);
    logic ch;
    ch = 1'($urandom_range(0, 1));
    repeat (count) begin
      // Pedals tend to come in runs so a filter can settle.
      if ($urandom_range(0, 9) >= 7) begin
        ch = ~ch;
      end
      send_sample(ch, draw_sample(ch));
    end
  endtask

  task automatic test_default_calibration();
    send_sample(PedBrake, 12'd0);
    repeat (3) send_sample(PedBrake, AdcMax);
    send_sample(PedAccel, AdcMax);
    send_sample(PedAccel, 12'd0);
    send_sample(PedAccel, 12'd2048);
    send_sample(PedBrake, 12'd0);
  endtask

  task automatic test_calibration_corners();
    // Reversed brake ends and an accelerator with equal ends (a step at 2000).
    program_calibration(12'd3800, 12'd300, 12'hFFE, 12'd2000, 12'd2000, 12'h002, 1'b0);
    send_sample(PedBrake, AdcMax);
    repeat (2) send_sample(PedAccel, 12'd2000);
    send_sample(PedAccel, AdcMax);
    // Full-range ends both ways, both inverted, plus writes to unused indexes.
    program_calibration(12'd0, AdcMax, 12'hFFF, AdcMax, 12'd0, 12'h001, 1'b1);
    send_sample(PedBrake, AdcMax);
    send_sample(PedBrake, 12'd0);
    repeat (2) send_sample(PedAccel, AdcMax);
    send_sample(PedAccel, 12'd0);
    // Both ends at a rail.
    program_calibration(12'd0, 12'd0, 12'h000, AdcMax, AdcMax, 12'h000, 1'b0);
    send_sample(PedBrake, 12'd1);
    send_sample(PedBrake, 12'd0);
    send_sample(PedAccel, AdcMax);
  endtask

  task automatic test_random_traffic();
    logic [padcfn_pkg::SampleW-1:0] b_lo;
    logic [padcfn_pkg::SampleW-1:0] b_hi;
    logic [padcfn_pkg::SampleW-1:0] a_lo;
    logic [padcfn_pkg::SampleW-1:0] a_hi;
    for (int p = 0; p < 6; p++) begin
      // Some phases run with one side or both sides never idling.
      tx_idle = (p % 3) != 2;
      rx_idle = (p % 2) == 0;
      if (p == 0) begin
        program_calibration(12'd0, AdcMax, 12'h000, 12'd0, AdcMax, 12'h000, 1'b0);
      end else if (p == 1) begin
        program_calibration(AdcMax, 12'd0, 12'h001, AdcMax, 12'd0, 12'h801, 1'b1);
      end else begin
        draw_calibration(b_lo, b_hi);
        draw_calibration(a_lo, a_hi);
        program_calibration(b_lo, b_hi, padcfn_pkg::CfgDataW'($urandom_range(0, 4095)),
                            a_lo, a_hi, padcfn_pkg::CfgDataW'($urandom_range(0, 4095)),
                            1'b0);
      end
      send_random_items(RandItemsPerPhase);
    end
    tx_idle = 1'b1;
    rx_idle = 1'b1;
  endtask

  // The receiver stops for a long stretch while samples keep coming, so the
  // block's output register fills and in_ready has to drop.
  task automatic test_output_stall();
    wait_drained();
    tx_idle = 1'b0;
    rx_hold_cycles = HoldCycles;
    send_random_items(StallItems);
    wait_drained();
    tx_idle = 1'b1;
  endtask

  task automatic report_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      error_count++;
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : check_results
    pedal_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        error_count++;
        $display("%0t ns: result transfer with nothing expected, expected none, %s %0d raw %0d",
                 $time, "actual ch", out_channel, out_raw_echo);
      end else begin
        want = pending_results.pop_front();
        report_field("channel", want.channel, out_channel);
        report_field("raw_echo", want.raw, out_raw_echo);
        report_field("smoothed", want.smoothed, out_smoothed);
        report_field("position", want.position, out_position);
        checked_count++;
      end
    end
  end

  initial begin : receiver
    int unsigned stall;
    while (!rst_n) @(posedge clk);
    forever begin
      if (rx_hold_cycles > 0) begin
        stall = rx_hold_cycles;
        rx_hold_cycles = 0;
      end else begin
        stall = rx_idle ? $urandom_range(0, 15) : 0;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin
    #20_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    for (int c = 0; c < 2; c++) begin
      filt_state[c] = '0;
      cal_lo[c] = padcfn_pkg::CalLowRst;
      cal_hi[c] = padcfn_pkg::CalHighRst;
      cal_inv[c] = 1'b0;
      last_sample[c] = '0;
    end
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    test_default_calibration();
    test_calibration_corners();
    test_output_stall();
    test_random_traffic();
    wait_drained();
    repeat (TailCycles) @(posedge clk);
    $display("Checked %0d of %0d samples on both pedals over %0d calibration settings,",
             checked_count, sent_count, settings_count);
    $display("with random gaps on both sides and a %0d-cycle output stall.", HoldCycles);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/padcfn_pkg.sv
hw/rtl/pedal_adc_filter_normalizer_top.sv
hw/rtl/padcfn_checker.sv
verif/tb.sv
